>>> hdl/cpsf_pkg.sv
// ----------------------------------------------------------------------------
// cpsf_pkg: shared types and constants
// Field widths, status and register codes, and the structs passed between
// the filter core and its submodules.
// ----------------------------------------------------------------------------
package cpsf_pkg;

  // Field widths
  localparam int unsigned LenW   = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MagicW = 16;
  localparam int unsigned SeqW   = 64;
  localparam int unsigned DurW   = 32;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned CntW   = 32;
  localparam int unsigned StatW  = 4;

  // Config port
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned IdxW   = 3;

  localparam logic [ByteW-1:0] MinLengthReset = 8'd1;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    StAccept     = 4'd0,
    StNotControl = 4'd1,
    StBadLength  = 4'd2,
    StBadMagic   = 4'd3,
    StBadVersion = 4'd4,
    StWrongNode  = 4'd5,
    StExpired    = 4'd6,
    StDuplicate  = 4'd7,
    StStale      = 4'd8
  } status_e;

  // Config register indexes (byte address = 4 * index)
  typedef enum logic [IdxW-1:0] {
    RegLocalNode       = 3'd0,
    RegExpectedType    = 3'd1,
    RegExpectedMagic   = 3'd2,
    RegExpectedVersion = 3'd3,
    RegMinLength       = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0]  local_node;
    logic [ByteW-1:0]  expected_type;
    logic [MagicW-1:0] expected_magic;
    logic [ByteW-1:0]  expected_version;
    logic [ByteW-1:0]  min_length;
  } cfg_t;

  // One unpacked packet header plus the current time
  typedef struct packed {
    logic [LenW-1:0]   packet_length;
    logic [ByteW-1:0]  type_byte;
    logic [MagicW-1:0] magic_word;
    logic [ByteW-1:0]  version_byte;
    logic [ByteW-1:0]  target_node;
    logic [SeqW-1:0]   seq_number;
    logic [DurW-1:0]   duration;
    logic [TimeW-1:0]  now_time;
  } pkt_t;

  // Filter decision, one flag per counter
  typedef struct packed {
    logic received;
    logic wrong_node;
    logic expired;
    logic duplicate;
    logic stale;
    logic accepted;
  } event_t;

  typedef struct packed {
    logic [CntW-1:0] received;
    logic [CntW-1:0] wrong_node;
    logic [CntW-1:0] expired;
    logic [CntW-1:0] duplicate;
    logic [CntW-1:0] stale;
    logic [CntW-1:0] accepted;
  } counts_t;

endpackage

>>> hdl/cpsf_if.sv
// ----------------------------------------------------------------------------
// cpsf interfaces: packet and result channels
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface cpsf_pkt_if import cpsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LenW-1:0]   packet_length;
  logic [ByteW-1:0]  type_byte;
  logic [MagicW-1:0] magic_word;
  logic [ByteW-1:0]  version_byte;
  logic [ByteW-1:0]  target_node;
  logic [SeqW-1:0]   seq_number;
  logic [DurW-1:0]   duration;
  logic [TimeW-1:0]  now_time;

  modport source (
    output valid, packet_length, type_byte, magic_word, version_byte,
    output target_node, seq_number, duration, now_time,
    input  ready
  );
  modport sink (
    input  valid, packet_length, type_byte, magic_word, version_byte,
    input  target_node, seq_number, duration, now_time,
    output ready
  );
endinterface

interface cpsf_res_if import cpsf_pkg::*; ();
  logic             valid;
  logic             ready;
  status_e          status;
  logic [TimeW-1:0] expiry_time;
  logic [CntW-1:0]  received_count;
  logic [CntW-1:0]  wrong_node_count;
  logic [CntW-1:0]  expired_count;
  logic [CntW-1:0]  duplicate_count;
  logic [CntW-1:0]  stale_count;
  logic [CntW-1:0]  accepted_count;

  modport source (
    output valid, status, expiry_time, received_count, wrong_node_count,
    output expired_count, duplicate_count, stale_count, accepted_count,
    input  ready
  );
  modport sink (
    input  valid, status, expiry_time, received_count, wrong_node_count,
    input  expired_count, duplicate_count, stale_count, accepted_count,
    output ready
  );
endinterface

>>> hdl/cpsf_classify.sv
// ----------------------------------------------------------------------------
// cpsf_classify: header checks and filter decision
// Parses one header against the config, forms the saturated expiry time and
// picks the filter outcome from the stored sequence state.
// ----------------------------------------------------------------------------
module cpsf_classify import cpsf_pkg::*; (
  input  cfg_t             cfg_i,
  input  pkt_t             pkt_i,
  input  logic             have_last_i,
  input  logic [SeqW-1:0]  last_seq_i,
  output status_e          status_o,
  output logic [TimeW-1:0] expiry_o,
  output event_t           event_o
);

  logic [TimeW:0]   sum;
  logic [TimeW-1:0] expiry_sat;
  logic             parsed;
  logic             expired;

  // Saturating now + duration
  assign sum        = {1'b0, pkt_i.now_time} + {{(TimeW + 1 - DurW){1'b0}}, pkt_i.duration};
  assign expiry_sat = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];

  // expiry <= now happens only for a zero duration or a saturated clock
  assign expired = (pkt_i.duration == '0) || (pkt_i.now_time == {TimeW{1'b1}});

  always_comb begin
    event_o = '0;
    parsed  = 1'b0;
    // header parse
    if ((pkt_i.packet_length == '0) || (pkt_i.type_byte != cfg_i.expected_type)) begin
      status_o = StNotControl;
    end else if (pkt_i.packet_length < {{(LenW - ByteW){1'b0}}, cfg_i.min_length}) begin
      status_o = StBadLength;
    end else if (pkt_i.magic_word != cfg_i.expected_magic) begin
      status_o = StBadMagic;
    end else if (pkt_i.version_byte != cfg_i.expected_version) begin
      status_o = StBadVersion;
    end else begin
      parsed           = 1'b1;
      event_o.received = 1'b1;
      // filter, first match wins
      if (pkt_i.target_node != cfg_i.local_node) begin
        status_o           = StWrongNode;
        event_o.wrong_node = 1'b1;
      end else if (expired) begin
        status_o        = StExpired;
        event_o.expired = 1'b1;
      end else if (have_last_i && (pkt_i.seq_number == last_seq_i)) begin
        status_o          = StDuplicate;
        event_o.duplicate = 1'b1;
      end else if (have_last_i && (pkt_i.seq_number < last_seq_i)) begin
        status_o      = StStale;
        event_o.stale = 1'b1;
      end else begin
        status_o         = StAccept;
        event_o.accepted = 1'b1;
      end
    end
  end

  assign expiry_o = parsed ? expiry_sat : '0;

endmodule

>>> hdl/cpsf_state.sv
// ----------------------------------------------------------------------------
// cpsf_state: sequence tracking and outcome counters
// Holds the last accepted sequence and six saturating counters, updated once
// per classified packet.
// ----------------------------------------------------------------------------
module cpsf_state import cpsf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            update_i,
  input  event_t          event_i,
  input  logic [SeqW-1:0] seq_i,
  output logic            have_last_o,
  output logic [SeqW-1:0] last_seq_o,
  output counts_t         counts_o
);

  logic            have_last_q;
  logic [SeqW-1:0] last_seq_q;
  counts_t         cnt_q;
  counts_t         cnt_d;

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] c, logic hit);
    logic [CntW-1:0] r;
    r = c;
    if (hit && (c != {CntW{1'b1}})) begin
      r = c + 1'b1;
    end
    return r;
  endfunction

  // next counter values
  always_comb begin
    cnt_d.received   = sat_inc(cnt_q.received,   event_i.received);
    cnt_d.wrong_node = sat_inc(cnt_q.wrong_node, event_i.wrong_node);
    cnt_d.expired    = sat_inc(cnt_q.expired,    event_i.expired);
    cnt_d.duplicate  = sat_inc(cnt_q.duplicate,  event_i.duplicate);
    cnt_d.stale      = sat_inc(cnt_q.stale,      event_i.stale);
    cnt_d.accepted   = sat_inc(cnt_q.accepted,   event_i.accepted);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_last_q <= 1'b0;
      last_seq_q  <= '0;
      cnt_q       <= '0;
    end else if (update_i) begin
      cnt_q <= cnt_d;
      if (event_i.accepted) begin
        have_last_q <= 1'b1;
        last_seq_q  <= seq_i;
      end
    end
  end

  assign have_last_o = have_last_q;
  assign last_seq_o  = last_seq_q;
  assign counts_o    = cnt_q;

endmodule

>>> hdl/control_packet_sequence_filter_core.sv
// ----------------------------------------------------------------------------
// control_packet_sequence_filter_core: control packet checker and filter
// Validates unpacked control packet headers, computes expiry, filters by node,
// expiry and sequence, and keeps saturating outcome counters.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake     Carries
//  pkt_i     in   valid/ready   header fields, sequence, duration, current time
//  res_o     out  valid/ready   status, expiry time, six counter values
//  APB       in   psel/penable  config registers at byte address 4*index
//
//  One packet per cycle sustained while results are taken; input register,
//  then result register, with the decision logic and a 64-bit add between.
//  Sequence state and counters update when a packet moves into the result
//  register, so each result carries the counts after its own packet.
//  A stalled result holds the pipe; the input register still takes one more
//  packet. Reset clears counters, sequence state and config to defaults.
// ----------------------------------------------------------------------------
module control_packet_sequence_filter_core import cpsf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  cpsf_pkt_if.sink         pkt_i,
  cpsf_res_if.source       res_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t             cfg_q;
  reg_idx_e         reg_idx;
  logic             cfg_wr;

  logic             s1_valid_q;
  pkt_t             s1_pkt_q;
  logic             out_valid_q;
  status_e          out_status_q;
  logic [TimeW-1:0] out_expiry_q;

  logic             out_free;
  logic             advance;
  logic             in_fire;

  status_e          status;
  logic [TimeW-1:0] expiry;
  event_t           event_s;
  logic             have_last;
  logic [SeqW-1:0]  last_seq;
  counts_t          counts;

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_node       <= '0;
      cfg_q.expected_type    <= '0;
      cfg_q.expected_magic   <= '0;
      cfg_q.expected_version <= '0;
      cfg_q.min_length       <= MinLengthReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegLocalNode:       cfg_q.local_node       <= pwdata[ByteW-1:0];
        RegExpectedType:    cfg_q.expected_type    <= pwdata[ByteW-1:0];
        RegExpectedMagic:   cfg_q.expected_magic   <= pwdata[MagicW-1:0];
        RegExpectedVersion: cfg_q.expected_version <= pwdata[ByteW-1:0];
        RegMinLength:       cfg_q.min_length       <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      RegLocalNode:       prdata = {{(DataW - ByteW){1'b0}}, cfg_q.local_node};
      RegExpectedType:    prdata = {{(DataW - ByteW){1'b0}}, cfg_q.expected_type};
      RegExpectedMagic:   prdata = {{(DataW - MagicW){1'b0}}, cfg_q.expected_magic};
      RegExpectedVersion: prdata = {{(DataW - ByteW){1'b0}}, cfg_q.expected_version};
      RegMinLength:       prdata = {{(DataW - ByteW){1'b0}}, cfg_q.min_length};
      default:            prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake
  // --------------------------------------------------------------------------
  assign out_free    = !out_valid_q || res_o.ready;
  assign advance     = s1_valid_q && out_free;
  assign pkt_i.ready = !s1_valid_q || advance;
  assign in_fire     = pkt_i.valid && pkt_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pkt_q.packet_length <= pkt_i.packet_length;
      s1_pkt_q.type_byte     <= pkt_i.type_byte;
      s1_pkt_q.magic_word    <= pkt_i.magic_word;
      s1_pkt_q.version_byte  <= pkt_i.version_byte;
      s1_pkt_q.target_node   <= pkt_i.target_node;
      s1_pkt_q.seq_number    <= pkt_i.seq_number;
      s1_pkt_q.duration      <= pkt_i.duration;
      s1_pkt_q.now_time      <= pkt_i.now_time;
    end
  end

  // --------------------------------------------------------------------------
  // Decision and state
  // --------------------------------------------------------------------------
  cpsf_classify u_classify (
    .cfg_i       (cfg_q),
    .pkt_i       (s1_pkt_q),
    .have_last_i (have_last),
    .last_seq_i  (last_seq),
    .status_o    (status),
    .expiry_o    (expiry),
    .event_o     (event_s)
  );

  cpsf_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .update_i    (advance),
    .event_i     (event_s),
    .seq_i       (s1_pkt_q.seq_number),
    .have_last_o (have_last),
    .last_seq_o  (last_seq),
    .counts_o    (counts)
  );

  // --------------------------------------------------------------------------
  // Result register; counters only move when a new result loads
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_status_q <= status;
      out_expiry_q <= expiry;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.status           = out_status_q;
  assign res_o.expiry_time      = out_expiry_q;
  assign res_o.received_count   = counts.received;
  assign res_o.wrong_node_count = counts.wrong_node;
  assign res_o.expired_count    = counts.expired;
  assign res_o.duplicate_count  = counts.duplicate;
  assign res_o.stale_count      = counts.stale;
  assign res_o.accepted_count   = counts.accepted;

endmodule

>>> hdl/cpsf_checker.sv
// ----------------------------------------------------------------------------
// cpsf_checker: port-level assertions for the filter core
// Watches the result channel and checks status, expiry and counter relations.
// ----------------------------------------------------------------------------
module cpsf_checker import cpsf_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input logic [StatW-1:0] status_i,
  input logic [TimeW-1:0] expiry_i,
  input logic [CntW-1:0]  received_i,
  input logic [CntW-1:0]  accepted_i
);

  logic parse_fail;

  assign parse_fail = (status_i == StNotControl) || (status_i == StBadLength) ||
                      (status_i == StBadMagic) || (status_i == StBadVersion);

  // result stays offered until taken
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result valid dropped before transaction");

  // a header that failed parse carries no expiry
  a_fail_no_expiry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && parse_fail |-> expiry_i == '0)
    else $error("nonzero expiry on parse failure");

  // an accepted packet has been counted both as received and accepted
  a_accept_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (status_i == StAccept) |-> (accepted_i != '0) && (received_i != '0))
    else $error("accepted packet not counted");

  // every accepted packet was also received
  a_accept_le_recv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> accepted_i <= received_i)
    else $error("accepted count exceeds received count");

endmodule

bind control_packet_sequence_filter_core cpsf_checker u_cpsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .status_i    (res_o.status),
  .expiry_i    (res_o.expiry_time),
  .received_i  (res_o.received_count),
  .accepted_i  (res_o.accepted_count)
);
